>>> hdl/egcd_pkg.sv
// Shared types and constants for the euclidean_gcd_core block.
// Holds the word widths and the controller/datapath command and status structs.
// No dependencies.
package egcd_pkg;

   localparam int DATA_WIDTH  = 64;
   localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);
   localparam int REQ_WIDTH   = 2 * DATA_WIDTH;

   typedef logic [DATA_WIDTH-1:0]  data_type;
   typedef logic [SHIFT_WIDTH-1:0] shift_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take the operands of a new word
      logic step;     // one reduction step
      logic capture;  // move the finished divisor into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic done;     // one operand has reached zero
   } status_type;

endpackage

>>> hdl/euclidean_gcd_core.sv
// Greatest common divisor of the magnitudes of two signed 64-bit integers.
// An item is loaded, then reduced step by step in the shared 64-bit compare/subtract
// unit, every step taking at least one bit off the two operands together; the common
// power of two is shifted back in as the result is captured, which waits until the
// output register has room. One item is worked on at a time; a finished result waits
// in the output register while the next word is taken.
// If both operands are zero the result is 0 and the both_zero flag in rsp_tuser is set.
// Depends on egcd_pkg, egcd_controller and egcd_datapath.
module euclidean_gcd_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [63:0] first_value, [127:64] second_value
   input  logic [egcd_pkg::REQ_WIDTH-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] divisor_result
   output logic [egcd_pkg::DATA_WIDTH-1:0]     rsp_tdata,
   // [0] both_zero
   output logic                                rsp_tuser
);
   import egcd_pkg::*;

   cmd_type    cmd;
   status_type status;

   egcd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   egcd_datapath u_dp (
      .clock          (clock),
      .first_value    (req_tdata[DATA_WIDTH-1:0]),
      .second_value   (req_tdata[REQ_WIDTH-1:DATA_WIDTH]),
      .cmd            (cmd),
      .status         (status),
      .divisor_result (rsp_tdata),
      .both_zero      (rsp_tuser)
   );

endmodule

>>> hdl/egcd_datapath.sv
// Datapath of the gcd core: operand registers, shared shift/subtract unit and output register.
// Binary reduction, one step per cycle. Depends on egcd_pkg.
module egcd_datapath (
   input  logic                    clock,
   input  egcd_pkg::data_type      first_value,
   input  egcd_pkg::data_type      second_value,
   input  egcd_pkg::cmd_type       cmd,
   output egcd_pkg::status_type    status,
   output egcd_pkg::data_type      divisor_result,
   output logic                    both_zero
);
   import egcd_pkg::*;

   data_type  a_ff, a_in;
   data_type  b_ff, b_in;
   shift_type k_ff, k_in;
   logic      zero_ff, zero_in;
   data_type  result_ff, result_in;
   logic      flag_ff, flag_in;

   data_type                mag_first;
   data_type                mag_second;
   logic [DATA_WIDTH:0]     diff_ab;
   data_type                diff_ba;

   // Magnitude as unsigned: the most negative value maps to 2^63
   assign mag_first  = first_value[DATA_WIDTH-1]  ? (~first_value + 1'b1)  : first_value;
   assign mag_second = second_value[DATA_WIDTH-1] ? (~second_value + 1'b1) : second_value;

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = b_ff - a_ff;

   assign status.done = (a_ff == '0) || (b_ff == '0);

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      zero_in   = zero_ff;
      result_in = result_ff;
      flag_in   = flag_ff;
      if (cmd.load) begin
         a_in    = mag_first;
         b_in    = mag_second;
         k_in    = '0;
         zero_in = (mag_first == '0) && (mag_second == '0);
      end else if (cmd.step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            // common factor of two: drop it from both and count it
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (!diff_ab[DATA_WIDTH]) begin
            // both odd: difference is even, halve it at once
            a_in = {1'b0, diff_ab[DATA_WIDTH-1:1]};
         end else begin
            b_in = {1'b0, diff_ba[DATA_WIDTH-1:1]};
         end
      end
      if (cmd.capture) begin
         // one operand is zero here, so the OR is the other one
         result_in = (a_ff | b_ff) << k_ff;
         flag_in   = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      zero_ff   <= zero_in;
      result_ff <= result_in;
      flag_ff   <= flag_in;
   end

   assign divisor_result = result_ff;
   assign both_zero      = flag_ff;

endmodule

>>> hdl/egcd_controller.sv
// Controller of the gcd core: accepts a word, runs the reduction, hands the result over.
// Drives the datapath through egcd_pkg::cmd_type. Depends on egcd_pkg.
module egcd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  egcd_pkg::status_type    status,
   output egcd_pkg::cmd_type       cmd
);
   import egcd_pkg::*;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_RUN  = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_tready;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!status.done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               // hold until the output register has room
               cmd.capture = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
